@@ sv/swa_pkg.sv @@
`default_nettype none

package swa_pkg;

    localparam int WINDOW_MAX_DEF  = 256;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int WREG_W          = 9;
    localparam int WINDOW_RESET    = 8;

    // head of the item queue as seen by the back end
    typedef struct packed {
        logic vld;
        logic fill;
    } q_head_t;

    // back end requests to the front end
    typedef struct packed {
        logic pop;
        logic hold;
    } q_ctrl_t;

endpackage

`default_nettype wire

@@ sv/sliding_window_average.sv @@
// Channel   Handshake                   Beat contents
// item      item_valid / item_stall     action, value
// result    result_valid / result_stall average
// window    window_we                   window_size
//
// Push: the result comes from the bit-serial divider, which produces one
// quotient bit per cycle. Fill: one store write per cycle. A two-beat queue
// takes items while the back end works.
// After reset a clearing pass zeroes the sample store; item_stall is high
// during it. The result register holds a beat under result_stall while the
// back end goes on with fills.
`default_nettype none

module sliding_window_average #(
    parameter int WINDOW_MAX  = swa_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swa_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          window_we,
    input  logic [swa_pkg::WREG_W-1:0]    window_size,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic                          action,
    input  logic signed [SAMPLE_BITS-1:0] value,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic signed [SAMPLE_BITS-1:0] average
);

    import swa_pkg::*;

    q_ctrl_t                       ctrl;
    q_head_t                       head;
    logic signed [SAMPLE_BITS-1:0] head_value;

    swa_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .action     (action),
        .value      (value),
        .ctrl       (ctrl),
        .head       (head),
        .head_value (head_value)
    );

    swa_back #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .window_we    (window_we),
        .window_size  (window_size),
        .head         (head),
        .head_value   (head_value),
        .ctrl         (ctrl),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .average      (average)
    );

endmodule

`default_nettype wire

@@ sv/swa_ram.sv @@
`default_nettype none

module swa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ sv/swa_front.sv @@
`default_nettype none

module swa_front #(
    parameter int SAMPLE_BITS = swa_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic                          action,
    input  logic signed [SAMPLE_BITS-1:0] value,
    input  swa_pkg::q_ctrl_t              ctrl,
    output swa_pkg::q_head_t              head,
    output logic signed [SAMPLE_BITS-1:0] head_value
);

    localparam int Q_DEPTH = 2;
    localparam int PTR_W   = $clog2(Q_DEPTH);
    localparam int CNT_W   = $clog2(Q_DEPTH + 1);

    logic                          act_mem [Q_DEPTH];
    logic signed [SAMPLE_BITS-1:0] val_mem [Q_DEPTH];
    logic [PTR_W-1:0]              wr_ptr_reg;
    logic [PTR_W-1:0]              rd_ptr_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [CNT_W-1:0]              cnt_next;
    logic                          push;
    logic                          pop;

    assign item_stall = (cnt_reg == CNT_W'(Q_DEPTH)) || ctrl.hold;
    assign push       = item_valid && !item_stall;
    assign pop        = ctrl.pop && head.vld;

    assign head.vld   = (cnt_reg != '0);
    assign head.fill  = act_mem[rd_ptr_reg];
    assign head_value = val_mem[rd_ptr_reg];

    always_comb
    begin
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            act_mem[wr_ptr_reg] <= action;
            val_mem[wr_ptr_reg] <= value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/swa_div.sv @@
`default_nettype none

module swa_div #(
    parameter int DIVIDEND_W = 24,
    parameter int DIVISOR_W  = 9
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  ge;
    logic [DIVISOR_W-1:0]  rem_next;

    // restoring division, one quotient bit per cycle; quo_reg shifts the
    // dividend out at the top while quotient bits enter at the bottom
    assign trial    = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign ge       = (trial >= {1'b0, dvs_reg});
    assign diff     = trial - {1'b0, dvs_reg};
    assign rem_next = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVIDEND_W);
                rem_reg  <= '0;
                dvs_reg  <= divisor;
                quo_reg  <= dividend;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[DIVIDEND_W-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/swa_back.sv @@
`default_nettype none

module swa_back #(
    parameter int WINDOW_MAX  = swa_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swa_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          window_we,
    input  logic [swa_pkg::WREG_W-1:0]    window_size,
    input  swa_pkg::q_head_t              head,
    input  logic signed [SAMPLE_BITS-1:0] head_value,
    output swa_pkg::q_ctrl_t              ctrl,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic signed [SAMPLE_BITS-1:0] average
);

    import swa_pkg::*;

    localparam int LG      = $clog2(WINDOW_MAX);
    localparam int SUM_W   = SAMPLE_BITS + LG;
    localparam int PW      = (WINDOW_MAX > 1) ? LG : 1;
    localparam int WIN_W   = $clog2(WINDOW_MAX + 1);
    localparam int CMP_W   = (WREG_W > WIN_W) ? WREG_W : WIN_W;
    localparam int WIN_RST = (WINDOW_RESET > WINDOW_MAX) ? WINDOW_MAX : WINDOW_RESET;

    localparam logic [SUM_W-1:0]       Q_NEG_LIM = SUM_W'(1) << (SAMPLE_BITS - 1);
    localparam logic [SUM_W-1:0]       Q_POS_LIM = Q_NEG_LIM - 1'b1;
    localparam logic [SAMPLE_BITS-1:0] S_MAX     = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] S_MIN     = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL,
        ST_UPD,
        ST_SIGN,
        ST_DIV,
        ST_HOLD
    } state_t;

    state_t                        state_reg;
    logic [WIN_W-1:0]              win_reg;
    logic [PW-1:0]                 pos_reg;
    logic [PW-1:0]                 idx_reg;
    logic signed [SUM_W-1:0]       sum_reg;
    logic signed [SAMPLE_BITS-1:0] val_reg;
    logic                          neg_reg;
    logic                          res_valid_reg;
    logic signed [SAMPLE_BITS-1:0] res_reg;

    logic [CMP_W-1:0]              ws_cmp;
    logic [WIN_W-1:0]              win_new;
    logic [WIN_W-1:0]              pos_ext;
    logic [WIN_W-1:0]              pos_inc;
    logic [PW-1:0]                 pos_fix;
    logic [PW-1:0]                 pos_adv;
    logic                          fill_last;
    logic                          clr_last;
    logic signed [SAMPLE_BITS-1:0] ram_rdata;
    logic signed [SUM_W-1:0]       sum_upd;
    logic signed [SUM_W-1:0]       sum_fill;
    logic [SUM_W-1:0]              mag;
    logic                          div_done;
    logic [SUM_W-1:0]              div_quo;
    logic [SUM_W-1:0]              quo_neg;
    logic [SAMPLE_BITS-1:0]        avg_sat;
    logic                          slot_free;
    logic                          ram_we;
    logic [PW-1:0]                 ram_waddr;
    logic [SAMPLE_BITS-1:0]        ram_wdata;
    logic                          ram_re;

    // zero acts as a window of one, oversize saturates
    assign ws_cmp  = CMP_W'(window_size);
    assign win_new = (window_size == '0)              ? WIN_W'(1) :
                     (ws_cmp > CMP_W'(WINDOW_MAX))    ? WIN_W'(WINDOW_MAX) :
                                                        WIN_W'(ws_cmp);

    assign pos_ext = WIN_W'(pos_reg);
    assign pos_fix = (pos_ext >= win_reg) ? '0 : pos_reg;
    assign pos_inc = pos_ext + 1'b1;
    assign pos_adv = (pos_inc >= win_reg) ? '0 : pos_inc[PW-1:0];

    assign fill_last = (WIN_W'(idx_reg) == (win_reg - 1'b1));
    assign clr_last  = (idx_reg == PW'(WINDOW_MAX - 1));

    assign sum_upd  = sum_reg - SUM_W'(ram_rdata) + SUM_W'(val_reg);
    assign sum_fill = sum_reg + SUM_W'(val_reg);
    assign mag      = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);

    assign quo_neg  = ~div_quo + 1'b1;
    assign avg_sat  = neg_reg ? ((div_quo > Q_NEG_LIM) ? S_MIN : quo_neg[SAMPLE_BITS-1:0])
                              : ((div_quo > Q_POS_LIM) ? S_MAX : div_quo[SAMPLE_BITS-1:0]);

    assign slot_free = !res_valid_reg || !result_stall;

    assign ctrl.pop  = (state_reg == ST_IDLE) && head.vld;
    assign ctrl.hold = (state_reg == ST_CLEAR);

    assign ram_we    = (state_reg == ST_CLEAR) || (state_reg == ST_FILL) ||
                       (state_reg == ST_UPD);
    assign ram_waddr = (state_reg == ST_UPD) ? pos_reg : idx_reg;
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0 : val_reg;
    assign ram_re    = ctrl.pop && !head.fill;

    assign result_valid = res_valid_reg;
    assign average      = res_reg;

    swa_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_MAX)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (pos_fix),
        .rdata (ram_rdata)
    );

    swa_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (WIN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_SIGN),
        .dividend (mag),
        .divisor  (win_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            win_reg       <= WIN_W'(WIN_RST);
            pos_reg       <= '0;
            idx_reg       <= '0;
            sum_reg       <= '0;
            val_reg       <= '0;
            neg_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            if (res_valid_reg && !result_stall)
            begin
                res_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (clr_last)
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (head.vld)
                    begin
                        val_reg <= head_value;
                        if (head.fill)
                        begin
                            idx_reg   <= '0;
                            sum_reg   <= '0;
                            state_reg <= ST_FILL;
                        end
                        else
                        begin
                            pos_reg   <= pos_fix;
                            state_reg <= ST_UPD;
                        end
                    end
                end
                ST_FILL:
                begin
                    sum_reg <= sum_fill;
                    idx_reg <= idx_reg + 1'b1;
                    if (fill_last)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_UPD:
                begin
                    // oldest sample is on the read port now; new one overwrites it
                    sum_reg   <= sum_upd;
                    pos_reg   <= pos_adv;
                    state_reg <= ST_SIGN;
                end
                ST_SIGN:
                begin
                    neg_reg   <= sum_reg[SUM_W-1];
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        if (slot_free)
                        begin
                            res_reg       <= avg_sat;
                            res_valid_reg <= 1'b1;
                            state_reg     <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_HOLD;
                        end
                    end
                end
                ST_HOLD:
                begin
                    if (slot_free)
                    begin
                        res_reg       <= avg_sat;
                        res_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (window_we)
            begin
                win_reg <= win_new;
                pos_reg <= '0;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/swa_checker.sv @@
`default_nettype none

module swa_checker #(
    parameter int SAMPLE_BITS = swa_pkg::SAMPLE_BITS_DEF
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   item_valid,
    input logic                   item_stall,
    input logic                   result_valid,
    input logic                   result_stall,
    input logic [SAMPLE_BITS-1:0] average
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(average))
        else $error("result beat changed under stall");

    a_result_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(result_valid) |-> $past(!result_stall))
        else $error("result beat withdrawn before it was taken");

    a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> item_stall)
        else $error("item taken during store clearing");

    a_stall_known: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid |-> !$isunknown(item_stall))
        else $error("item_stall unknown");

endmodule

bind sliding_window_average swa_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_swa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .average      (average)
);

`default_nettype wire

@@ verif/sliding_window_average_tb.sv @@
module sliding_window_average_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W   = swa_pkg::SAMPLE_BITS_DEF;
    localparam int RING_DEPTH = swa_pkg::WINDOW_MAX_DEF;
    localparam int SUM_W      = SAMPLE_W + $clog2(RING_DEPTH);
    localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_FILL = 1'b1;

    localparam int IDLE_PCT    = 37;
    localparam int FILL_PCT    = 8;
    localparam int PHASE_ITEMS = 100;
    localparam int RAND_PHASES = 13;
    localparam int HOLD_PHASE  = 1;
    localparam int PAUSE_PHASE = 3;
    localparam int QUIET_PHASE = 6;
    localparam int LONG_HOLD   = 400;
    // margin for two queued fills plus one in flight
    localparam int FILL_DRAIN_CYCLES = 3 * (RING_DEPTH + 1) + 64;

    typedef enum logic [1:0] {ROW_PUSH, ROW_FILL, ROW_WINDOW} row_kind_t;

    typedef struct packed {
        row_kind_t kind;
        int        arg;
        logic      typed;
        int        avg;
    } stim_row_t;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              window_we;
    logic [swa_pkg::WREG_W-1:0]        window_size;
    logic                              item_valid;
    logic                              item_stall;
    logic                              action;
    logic signed [SAMPLE_W-1:0]        value;
    logic                              result_valid;
    logic                              result_stall;
    logic signed [SAMPLE_W-1:0]        average;

    // filter state mirrored from the outside
    logic [swa_pkg::WREG_W-1:0]        win_reg;
    logic signed [SAMPLE_W-1:0]        ring [RING_DEPTH];
    logic signed [SUM_W-1:0]           acc;
    int unsigned                       wpos;

    logic signed [SAMPLE_W-1:0]        pending_averages [$];
    logic signed [SAMPLE_W-1:0]        head_avg;
    int                                bad_beats = 0;
    int                                idle_pct = IDLE_PCT;
    bit                                hold_req = 1'b0;

    // typed averages: window stays 8 until the first window row
    stim_row_t directed_rows [0:26] = '{
        '{ROW_PUSH,    32767, 1'b1,   4095},
        '{ROW_PUSH,   -32768, 1'b1,      0},
        '{ROW_PUSH,        0, 1'b0,      0},
        '{ROW_FILL,   -32768, 1'b0,      0},
        '{ROW_PUSH,   -32768, 1'b1, -32768},
        '{ROW_FILL,    32767, 1'b0,      0},
        '{ROW_PUSH,    32767, 1'b1,  32767},
        '{ROW_WINDOW,      1, 1'b0,      0},
        '{ROW_FILL,       -1, 1'b0,      0},
        '{ROW_PUSH,    12345, 1'b1,  12345},
        '{ROW_PUSH,   -32768, 1'b1, -32768},
        '{ROW_WINDOW,    256, 1'b0,      0},
        '{ROW_FILL,    32767, 1'b0,      0},
        '{ROW_PUSH,   -32768, 1'b0,      0},
        // window shrunk with no fill: stale sum, average clips high
        '{ROW_WINDOW,      1, 1'b0,      0},
        '{ROW_PUSH,        0, 1'b1,  32767},
        '{ROW_WINDOW,      0, 1'b0,      0},
        '{ROW_PUSH,        1, 1'b0,      0},
        '{ROW_FILL,   -32768, 1'b0,      0},
        '{ROW_PUSH,        5, 1'b1,      5},
        // above the store depth: clamps to full depth, sum hits its minimum
        '{ROW_WINDOW,    511, 1'b0,      0},
        '{ROW_FILL,   -32768, 1'b0,      0},
        '{ROW_PUSH,   -32768, 1'b1, -32768},
        '{ROW_WINDOW,      1, 1'b0,      0},
        '{ROW_PUSH,   -32768, 1'b1, -32768},
        '{ROW_PUSH,    21845, 1'b0,      0},
        '{ROW_PUSH,   -21846, 1'b0,      0}
    };

    sliding_window_average u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .window_we    (window_we),
        .window_size  (window_size),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .action       (action),
        .value        (value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .average      (average)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int unsigned eff_window();
        if (win_reg == 0)
            return 1;
        if (win_reg > RING_DEPTH)
            return RING_DEPTH;
        return win_reg;
    endfunction

    // returns 1 when the beat produces an average
    function automatic bit advance_filter(input logic act, input logic signed [SAMPLE_W-1:0] val,
                                          output logic signed [SAMPLE_W-1:0] avg);
        int unsigned win;
        longint      q;
        longint      prod;

        win = eff_window();
        avg = '0;
        if (act == ACT_FILL)
        begin
            for (int unsigned i = 0; i < win; i++)
                ring[i] = val;
            prod = longint'(val) * longint'(win);
            acc = prod[SUM_W-1:0];
            return 1'b0;
        end
        if (wpos >= win)
            wpos = 0;
        acc = acc - ring[wpos];
        ring[wpos] = val;
        acc = acc + val;
        q = longint'(acc) / longint'(win);
        if (q > SAMPLE_MAX)
            q = SAMPLE_MAX;
        else if (q < SAMPLE_MIN)
            q = SAMPLE_MIN;
        avg = q[SAMPLE_W-1:0];
        wpos = (wpos + 1 >= win) ? 0 : wpos + 1;
        return 1'b1;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0: return SAMPLE_MAX[SAMPLE_W-1:0];
            1: return SAMPLE_MIN[SAMPLE_W-1:0];
            2: return SAMPLE_W'(int'($urandom_range(6)) - 3);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [swa_pkg::WREG_W-1:0] pick_window();
        int r;

        r = $urandom_range(99);
        if (r < 40)
            return swa_pkg::WREG_W'($urandom_range(1, 8));
        if (r < 70)
            return swa_pkg::WREG_W'($urandom_range(9, 32));
        if (r < 85)
            return swa_pkg::WREG_W'($urandom_range(33, RING_DEPTH - 1));
        if (r < 95)
            return swa_pkg::WREG_W'(RING_DEPTH);
        if (r < 97)
            return '0;
        return swa_pkg::WREG_W'($urandom_range(RING_DEPTH + 1, (1 << swa_pkg::WREG_W) - 1));
    endfunction

    task automatic send_beat(input logic act, input logic signed [SAMPLE_W-1:0] val,
                             input logic typed, input logic signed [SAMPLE_W-1:0] typed_avg);
        logic signed [SAMPLE_W-1:0] avg;

        while ($urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        action     <= act;
        value      <= val;
        do @(posedge clk); while (item_stall);
        if (advance_filter(act, val, avg))
            pending_averages.push_back(typed ? typed_avg : avg);
    endtask

    // always waits on the clock before returning so item_valid is never assigned twice in a step
    task automatic wait_results_done();
        item_valid <= 1'b0;
        do @(posedge clk); while (pending_averages.size() != 0);
    endtask

    task automatic change_window(input logic [swa_pkg::WREG_W-1:0] w);
        wait_results_done();
        // fills produce no beat, so give any queued ones time to finish
        repeat (FILL_DRAIN_CYCLES) @(posedge clk);
        window_size <= w;
        window_we   <= 1'b1;
        @(posedge clk);
        window_we   <= 1'b0;
        win_reg = w;
        wpos = 0;
    endtask

    // receiver: random stalls, plus one long hold on request
    initial
    begin
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                result_stall <= 1'b1;
                repeat (LONG_HOLD - 1) @(posedge clk);
            end
            else
            begin
                result_stall <= ($urandom_range(99) < idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_averages.size() == 0)
            begin
                $display("%0t: average beat %0d with none expected", $time, average);
                bad_beats++;
            end
            else
            begin
                head_avg = pending_averages.pop_front();
                if (average !== head_avg)
                begin
                    $display("%0t: average expected %0d actual %0d", $time, head_avg, average);
                    bad_beats++;
                end
            end
        end
    end

    initial
    begin
        #40ms;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        rst_n       <= 1'b0;
        window_we   <= 1'b0;
        window_size <= swa_pkg::WREG_W'(swa_pkg::WINDOW_RESET);
        item_valid  <= 1'b0;
        action      <= ACT_PUSH;
        value       <= '0;
        win_reg = swa_pkg::WREG_W'(swa_pkg::WINDOW_RESET);
        foreach (ring[i])
            ring[i] = '0;
        acc = '0;
        wpos = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            case (directed_rows[i].kind)
                ROW_PUSH:
                    send_beat(ACT_PUSH, SAMPLE_W'(directed_rows[i].arg), directed_rows[i].typed,
                              SAMPLE_W'(directed_rows[i].avg));
                ROW_FILL:
                    send_beat(ACT_FILL, SAMPLE_W'(directed_rows[i].arg), 1'b0, '0);
                default:
                    change_window(swa_pkg::WREG_W'(directed_rows[i].arg));
            endcase
        end

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            idle_pct = IDLE_PCT;
            change_window(pick_window());
            // now and then skip the fill and run on a stale sum
            if ($urandom_range(9) != 0)
                send_beat(ACT_FILL, pick_sample(), 1'b0, '0);
            if (ph == QUIET_PHASE)
                idle_pct = 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == HOLD_PHASE && n == 10)
                    hold_req = 1'b1;
                if (n == PHASE_ITEMS / 2 && (ph == PAUSE_PHASE || $urandom_range(3) == 0))
                    wait_results_done();
                send_beat(($urandom_range(99) < FILL_PCT) ? ACT_FILL : ACT_PUSH, pick_sample(),
                          1'b0, '0);
            end
        end

        idle_pct = IDLE_PCT;
        wait_results_done();
        repeat (FILL_DRAIN_CYCLES) @(posedge clk);
        if (bad_beats == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
